@@ hw/rtl/gpioirq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gpioirq_pkg;

  localparam int PORT_W = 8;

  // Item commands
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  // Read selectors (code 3 is unused and reads zero)
  typedef enum logic [1:0] {
    SEL_PIN_DATA   = 2'd0,
    SEL_RAW_STATUS = 2'd1,
    SEL_MIS_STATUS = 2'd2
  } read_sel_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DIRECTION  = 3'd0,
    REG_DIG_ENABLE = 3'd1,
    REG_SENSE      = 3'd2,
    REG_BOTH_EDGES = 3'd3,
    REG_EVENT      = 3'd4,
    REG_UNMASKED   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic              valid;
    logic [2:0]        index;
    logic [PORT_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PORT_W-1:0] pin_mask;
    logic [PORT_W-1:0] write_value;
    logic [1:0]        read_select;
    logic [PORT_W-1:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic              irq;
    logic [PORT_W-1:0] read_value;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/gpioirq_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpioirq_core
  import gpioirq_pkg::*;
#(
  parameter logic [PORT_W-1:0] PortMask = '1
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_wr_t cfg,
  input  wire logic    item_valid,
  input  wire item_t   item,
  output result_t      result
);

  logic [PORT_W-1:0] dir_r, den_r, sense_r, both_r, event_r, unmask_r;
  logic [PORT_W-1:0] latch_r, latch_nxt;
  logic [PORT_W-1:0] prev_r, prev_nxt;
  logic [PORT_W-1:0] cur_r, cur_nxt;
  logic [PORT_W-1:0] raw_r, raw_nxt;

  logic [PORT_W-1:0] mask, wval, levels, rise, fall, edge_hit, level_hit, hit;
  logic [PORT_W-1:0] pin_data, rd;

  assign mask   = item.pin_mask & PortMask;
  assign wval   = item.write_value & PortMask;
  assign levels = item.pin_levels & PortMask;

  // Edge and level detection against the last sampled levels
  assign rise      = ~cur_r & levels;
  assign fall      = cur_r & ~levels;
  assign edge_hit  = (both_r & (rise | fall))
                   | (~both_r & ((event_r & rise) | (~event_r & fall)));
  assign level_hit = (event_r & levels) | (~event_r & ~levels);
  assign hit       = ((sense_r & level_hit) | (~sense_r & edge_hit)) & PortMask;

  assign pin_data = ((dir_r & latch_r) | (~dir_r & cur_r)) & den_r;

  always_comb begin
    latch_nxt = latch_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    raw_nxt   = raw_r;
    rd        = '0;
    unique case (cmd_t'(item.cmd))
      CMD_WRITE: begin
        latch_nxt = (latch_r & ~mask) | (wval & mask);
      end
      CMD_READ: begin
        unique case (item.read_select)
          SEL_PIN_DATA:   rd = pin_data & mask;
          SEL_RAW_STATUS: rd = raw_r & mask;
          SEL_MIS_STATUS: rd = raw_r & unmask_r & mask;
          default:        rd = '0;
        endcase
      end
      CMD_CLEAR: begin
        raw_nxt = raw_r & ~(wval & mask);
      end
      CMD_SAMPLE: begin
        prev_nxt = cur_r;
        cur_nxt  = levels;
        raw_nxt  = raw_r | hit;
      end
    endcase
  end

  assign result.read_value = rd;
  assign result.irq        = |(raw_nxt & unmask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
      prev_r  <= '0;
      cur_r   <= '0;
      raw_r   <= '0;
    end else if (item_valid) begin
      latch_r <= latch_nxt;
      prev_r  <= prev_nxt;
      cur_r   <= cur_nxt;
      raw_r   <= raw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= '0;
      den_r    <= '0;
      sense_r  <= '0;
      both_r   <= '0;
      event_r  <= '0;
      unmask_r <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DIRECTION:  dir_r    <= cfg.data & PortMask;
        REG_DIG_ENABLE: den_r    <= cfg.data & PortMask;
        REG_SENSE:      sense_r  <= cfg.data & PortMask;
        REG_BOTH_EDGES: both_r   <= cfg.data & PortMask;
        REG_EVENT:      event_r  <= cfg.data & PortMask;
        REG_UNMASKED:   unmask_r <= cfg.data & PortMask;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gpio_port_with_pin_interrupts_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Eight-pin GPIO port with per-pin edge/level interrupt detection. Each input
// word is one command: a masked write of the output latch, a masked read (pin
// data, raw status or masked status), a write-one-to-clear of raw status, or a
// pin sample tick that compares the new levels with the previous tick. Every
// word yields exactly one result word holding the read data (zero unless a
// read) and irq, the OR of masked status after the command took effect. The
// block takes one word per clock: all work is bitwise logic from the stored
// port state to the result register, and a one-word skid slot behind that
// register keeps the input open while a result waits; a full skid slot stalls
// the input. Configuration writes are accepted every cycle (cfg_ready is tied
// high); indexes past the last register are ignored. Pins at or above
// PIN_COUNT read as zero and never interrupt.

module gpio_port_with_pin_interrupts_top
  import gpioirq_pkg::*;
#(
  parameter int PIN_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // command words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // pin_mask[7:0], write_value[15:8], pin_levels[23:16]
  input  wire logic [3:0]  in_tuser,   // cmd[1:0], read_select[3:2]
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // read_value[7:0], irq[8], zero[15:9]
);

  localparam logic [PORT_W-1:0] PortMask =
    (PIN_COUNT >= PORT_W) ? '1 : PORT_W'((64'd1 << PIN_COUNT) - 64'd1);

  cfg_wr_t cfg;
  item_t   item;
  result_t result;
  logic    accept;

  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;

  assign cfg_ready  = 1'b1;
  assign cfg.valid  = cfg_valid;
  assign cfg.index  = cfg_index;
  assign cfg.data   = cfg_data;

  assign item.cmd         = in_tuser[1:0];
  assign item.read_select = in_tuser[3:2];
  assign item.pin_mask    = in_tdata[7:0];
  assign item.write_value = in_tdata[15:8];
  assign item.pin_levels  = in_tdata[23:16];

  // input stays open until the skid slot is taken
  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;

  gpioirq_core #(
    .PortMask (PortMask)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (accept),
    .item       (item),
    .result     (result)
  );

  // result register plus one skid word
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_tvalid && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (skid_valid_r && !out_valid_nxt) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (accept) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r.irq, out_data_r.read_value};

  // skid word never sits without a word in the output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  // a non-read word landing straight in the output register reads zero
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_tuser[1:0] != CMD_READ) && (!out_valid_r || out_tready))
      |=> (out_tdata[7:0] == 8'd0))
    else $error("non-read command returned nonzero read data");

  // reset empties the result path
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("result path not empty after reset");

endmodule

`default_nettype wire
